// ----- sv/postscript_token_splitter_core_assert.svh -----
// Assertion macros for the PostScript token splitter.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef POSTSCRIPT_TOKEN_SPLITTER_CORE_ASSERT_SVH
`define POSTSCRIPT_TOKEN_SPLITTER_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pts_pkg.sv -----
// Shared types, byte codes and classifiers for the PostScript token splitter.
// No dependencies.
package pts_pkg;

    localparam int DEPTH_W = 8;
    localparam logic [DEPTH_W-1:0] MAX_NEST = 8'd255;

    // Scanner modes, one-hot.
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_WORD    = 6'b000100,
        MODE_LIT     = 6'b001000,
        MODE_LIT_ESC = 6'b010000,
        MODE_HEX     = 6'b100000
    } mode_t;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_WORD    = 3'd1;
    localparam logic [2:0] KIND_LIT     = 3'd2;
    localparam logic [2:0] KIND_HEX     = 3'd3;
    localparam logic [2:0] KIND_BRACKET = 3'd4;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // One result item.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       in_token;
        logic       starts_token;
        logic       ends_token;
        logic       ends_previous;
        logic [2:0] token_kind;
    } res_t;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        return b inside {CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_LBRACK,
                         CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_SLASH, CH_PERCENT};
    endfunction

    function automatic logic is_bracket(input logic [7:0] b);
        return b inside {CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE};
    endfunction

endpackage

// ----- sv/pts_step.sv -----
// Next-state and result logic for one byte of the token splitter.
// Depends on pts_pkg.
module pts_step (
    input  pts_pkg::mode_t                mode,
    input  logic [pts_pkg::DEPTH_W-1:0]   depth,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_data,
    output pts_pkg::mode_t                mode_next,
    output logic [pts_pkg::DEPTH_W-1:0]   depth_next,
    output pts_pkg::res_t                 res
);
    import pts_pkg::*;

    // Decode of a byte seen between tokens.
    mode_t              st_mode;
    logic [DEPTH_W-1:0] st_depth;
    logic               st_in;
    logic               st_ends;
    logic [2:0]         st_kind;
    logic [DEPTH_W-1:0] depth_dec;

    always_comb
    begin
        st_mode  = MODE_IDLE;
        st_depth = depth;
        st_in    = 1'b0;
        st_ends  = 1'b0;
        st_kind  = KIND_NONE;
        if (data_byte == CH_PERCENT)
        begin
            st_mode = MODE_COMMENT;
        end
        else if (!is_space(data_byte))
        begin
            st_in = 1'b1;
            if (data_byte == CH_LPAREN)
            begin
                st_mode  = MODE_LIT;
                st_depth = DEPTH_W'(1);
                st_kind  = KIND_LIT;
            end
            else if (data_byte == CH_LT)
            begin
                st_mode = MODE_HEX;
                st_kind = KIND_HEX;
            end
            else if (is_bracket(data_byte))
            begin
                st_ends = 1'b1;
                st_kind = KIND_BRACKET;
            end
            else
            begin
                st_mode = MODE_WORD;
                st_kind = KIND_WORD;
            end
        end
    end

    assign depth_dec = (depth != '0) ? depth - DEPTH_W'(1) : '0;

    always_comb
    begin
        res        = '0;
        mode_next  = mode;
        depth_next = depth;
        if (end_of_data)
        begin
            res.ends_previous = (mode == MODE_WORD) || (mode == MODE_LIT) ||
                                (mode == MODE_LIT_ESC) || (mode == MODE_HEX);
            mode_next  = MODE_IDLE;
            depth_next = '0;
        end
        else
        begin
            res.byte_out = data_byte;
            case (mode)
                MODE_COMMENT:
                begin
                    if (data_byte == CH_LF || data_byte == CH_CR)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_WORD:
                begin
                    if (is_space(data_byte))
                    begin
                        res.ends_previous = 1'b1;
                        mode_next         = MODE_IDLE;
                    end
                    else if (is_special(data_byte))
                    begin
                        // close the word and start the next token on this byte
                        res.ends_previous = 1'b1;
                        res.in_token      = st_in;
                        res.starts_token  = st_in;
                        res.ends_token    = st_ends;
                        res.token_kind    = st_kind;
                        mode_next         = st_mode;
                        depth_next        = st_depth;
                    end
                    else
                    begin
                        res.in_token   = 1'b1;
                        res.token_kind = KIND_WORD;
                    end
                end
                MODE_LIT:
                begin
                    res.in_token   = 1'b1;
                    res.token_kind = KIND_LIT;
                    if (data_byte == CH_LPAREN)
                    begin
                        if (depth < MAX_NEST)
                        begin
                            depth_next = depth + DEPTH_W'(1);
                        end
                    end
                    else if (data_byte == CH_RPAREN)
                    begin
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                        begin
                            res.ends_token = 1'b1;
                            mode_next      = MODE_IDLE;
                        end
                    end
                    else if (data_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_LIT_ESC;
                    end
                end
                MODE_LIT_ESC:
                begin
                    res.in_token   = 1'b1;
                    res.token_kind = KIND_LIT;
                    mode_next      = MODE_LIT;
                end
                MODE_HEX:
                begin
                    res.in_token   = 1'b1;
                    res.token_kind = KIND_HEX;
                    if (data_byte == CH_GT)
                    begin
                        res.ends_token = 1'b1;
                        mode_next      = MODE_IDLE;
                    end
                end
                default:
                begin
                    res.in_token     = st_in;
                    res.starts_token = st_in;
                    res.ends_token   = st_ends;
                    res.token_kind   = st_kind;
                    mode_next        = st_mode;
                    depth_next       = st_depth;
                end
            endcase
        end
    end

endmodule

// ----- sv/postscript_token_splitter_core.sv -----
// PostScript token splitter: a byte stream in, one boundary-marked result per byte out.
// Depends on pts_pkg, pts_step and postscript_token_splitter_core_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one byte per transaction, or an
//   end marker (end_of_data = 1) that closes any open token and returns the
//   scanner to its between-tokens state.
//   Output channel (out_valid / out_stall) returns exactly one result transaction
//   per input transaction, in order: the byte, whether it belongs to a token,
//   start / end marks, the close of a preceding word, and the token kind.
//   A word's end shows as ends_previous on the byte (or end marker) after it.
//   Path: an accepted transaction is held in the input register, passes the
//   scanner step and is presented from the result register.
//   Throughput: one transaction per cycle while the receiver does not stall,
//   set by the combinational scanner step between the input and result registers.
//   Stall: when the receiver stalls, the result register holds; the input
//   register still fills, and in_stall rises only once both stages are full.
//   Reset (rst_n low, asynchronous): both stages empty, scanner between tokens,
//   literal-string depth zero.
module postscript_token_splitter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_out,
    output logic       in_token,
    output logic       starts_token,
    output logic       ends_token,
    output logic       ends_previous,
    output logic [2:0] token_kind
);
    import pts_pkg::*;

    // Input register stage.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eod_reg;
    logic       s1_advance;
    logic       s1_load;

    // Scanner state, updated as each transaction leaves the input stage.
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;

    // Result register stage.
    logic out_valid_reg;
    res_t res_reg;
    res_t res_next;

    // The input stage moves on whenever the result register is empty or being taken.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load    = in_valid && !in_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Payload: hold unless a new transaction lands.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_byte_reg <= data_byte;
            s1_eod_reg  <= end_of_data;
        end
    end

    pts_step u_step (
        .mode        (mode_reg),
        .depth       (depth_reg),
        .data_byte   (s1_byte_reg),
        .end_of_data (s1_eod_reg),
        .mode_next   (mode_next),
        .depth_next  (depth_next),
        .res         (res_next)
    );

    // Advance the scanner only when the transaction actually moves to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            depth_reg <= '0;
        end
        else if (s1_advance)
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_out      = res_reg.byte_out;
    assign in_token      = res_reg.in_token;
    assign starts_token  = res_reg.starts_token;
    assign ends_token    = res_reg.ends_token;
    assign ends_previous = res_reg.ends_previous;
    assign token_kind    = res_reg.token_kind;

`include "postscript_token_splitter_core_assert.svh"

    // A nonzero depth only exists inside a literal string.
    `PTS_ASSERT(a_depth_in_string, (depth_reg != '0) |-> (mode_reg == MODE_LIT || mode_reg == MODE_LIT_ESC), "paren depth set outside a literal string")
    // An end marker leaves the scanner fully reset.
    `PTS_ASSERT(a_eod_resets, (s1_advance && s1_eod_reg) |=> (mode_reg == MODE_IDLE && depth_reg == '0), "end marker did not reset scanner")
    // A token end mark is only given to a byte inside a token.
    `PTS_ASSERT(a_end_in_token, (out_valid_reg && res_reg.ends_token) |-> res_reg.in_token, "ends_token outside a token")
    // A starting byte always carries a kind.
    `PTS_ASSERT(a_start_kind, (out_valid_reg && res_reg.starts_token) |-> (res_reg.token_kind != KIND_NONE), "token start without kind")
    // Nothing leaves the input stage without space in the result register.
    `PTS_ASSERT_ALWAYS(a_no_overrun, (s1_advance && out_valid_reg) |-> !out_stall, "result register overrun")

endmodule
